@@ rtl/sector_cache_clock_tags_core_assert.svh @@
// Assertion macros for the sector cache tag engine
`ifndef SECTOR_CACHE_CLOCK_TAGS_CORE_ASSERT_SVH
`define SECTOR_CACHE_CLOCK_TAGS_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SCTC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SCTC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCTC_ASSERT(label, clk, rst, prop, msg)
`define SCTC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ rtl/sctc_pkg.sv @@
// Shared types and constants for the sector cache tag engine
package sctc_pkg;
   localparam int DEF_CACHE_SLOTS = 64;
   localparam int DEF_SECTOR_BITS = 32;

   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_FLUSH   = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] sector;
   } req_type;

   typedef struct packed {
      logic [5:0]  slot;
      logic        hit;
      logic        fetch_needed;
      logic        writeback_valid;
      logic [31:0] writeback_sector;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic is_flush;
      logic is_release;
      logic is_write;
   } cls_type;
endpackage

@@ rtl/sctc_front.sv @@
// Request intake: classify each request and queue it for the back end
module sctc_front #(
   parameter int SECTOR_BITS = sctc_pkg::DEF_SECTOR_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sctc_pkg::req_type      req_payload,
   output logic                   q_valid,
   output sctc_pkg::cls_type      q_cls,
   output logic [SECTOR_BITS-1:0] q_sector,
   input  logic                   q_pop
);
   sctc_pkg::cls_type      cls_ff [2];
   logic [SECTOR_BITS-1:0] sec_ff [2];
   logic [1:0]             count_ff, count_in;
   logic                   wr_ptr_ff, rd_ptr_ff;
   sctc_pkg::cls_type      cls;
   logic [63:0]            sec_ext;
   logic                   push;

   always_comb begin
      cls = '0;
      case (req_payload.op)
         sctc_pkg::OP_READ:    cls = '0;
         sctc_pkg::OP_WRITE:   cls.is_write = 1'b1;
         sctc_pkg::OP_RELEASE: cls.is_release = 1'b1;
         sctc_pkg::OP_FLUSH:   cls.is_flush = 1'b1;
         default:              cls = '0;
      endcase
   end

   assign sec_ext   = {32'd0, req_payload.sector};
   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_cls     = cls_ff[rd_ptr_ff];
   assign q_sector  = sec_ff[rd_ptr_ff];
   assign count_in  = count_ff + {1'b0, push} - {1'b0, q_pop && q_valid};

   always_ff @(posedge clock) begin
      if (push) begin
         cls_ff[wr_ptr_ff] <= cls;
         sec_ff[wr_ptr_ff] <= sec_ext[SECTOR_BITS-1:0];
      end
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop && q_valid) rd_ptr_ff <= ~rd_ptr_ff;
      end
   end
endmodule

@@ rtl/sctc_back.sv @@
// Lookup, replacement sweep, flush walk and result register
`include "sector_cache_clock_tags_core_assert.svh"
module sctc_back #(
   parameter int CACHE_SLOTS = sctc_pkg::DEF_CACHE_SLOTS,
   parameter int SECTOR_BITS = sctc_pkg::DEF_SECTOR_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  sctc_pkg::cls_type      q_cls,
   input  logic [SECTOR_BITS-1:0] q_sector,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sctc_pkg::rsp_type      rsp_payload
);
   localparam int IW = $clog2(CACHE_SLOTS);
   localparam logic [IW-1:0] LAST_SLOT = IW'(CACHE_SLOTS - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MATCH  = 3'd1;
   localparam logic [2:0] S_PICK   = 3'd2;
   localparam logic [2:0] S_SWEEP  = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;
   localparam logic [2:0] S_FL_RD  = 3'd5;
   localparam logic [2:0] S_FL_OUT = 3'd6;

   logic [2:0]             state_ff, state_in;
   sctc_pkg::cls_type      cls_ff;
   logic [SECTOR_BITS-1:0] sec_ff;
   logic [CACHE_SLOTS-1:0] match_ff, match_in;
   logic [CACHE_SLOTS-1:0] valid_ff, valid_in, ref_ff, ref_in, dirty_ff, dirty_in;
   logic [SECTOR_BITS-1:0] tag_ff [CACHE_SLOTS];
   logic [SECTOR_BITS-1:0] mem [CACHE_SLOTS];
   logic [SECTOR_BITS-1:0] mem_q_ff;
   logic [IW-1:0]          hand_ff, hand_in, sel_ff, sel_in, sel_next;
   logic                   hit_ff, hit_in, fetch_ff, fetch_in, wb_ff, wb_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sctc_pkg::rsp_type      rsp_ff, rsp_in;
   logic                   m_any, f_any, can_emit, fill_we;
   logic [IW-1:0]          m_idx, f_idx;
   logic [63:0]            mem_ext;

   always_comb begin
      for (int i = 0; i < CACHE_SLOTS; i++) begin
         match_in[i] = valid_ff[i] && (tag_ff[i] == sec_ff);
      end
   end

   always_comb begin
      m_any = 1'b0;
      m_idx = '0;
      f_any = 1'b0;
      f_idx = '0;
      for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            m_any = 1'b1;
            m_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            f_any = 1'b1;
            f_idx = IW'(i);
         end
      end
   end

   assign can_emit = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;
   assign sel_next = (sel_ff == LAST_SLOT) ? '0 : sel_ff + 1'b1;
   assign mem_ext  = 64'(mem_q_ff);

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      ref_in       = ref_ff;
      dirty_in     = dirty_ff;
      hand_in      = hand_ff;
      sel_in       = sel_ff;
      hit_in       = hit_ff;
      fetch_in     = fetch_ff;
      wb_in        = wb_ff;
      fill_we      = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) state_in = S_MATCH;
         end
         S_MATCH: state_in = S_PICK;
         S_PICK: begin
            hit_in   = 1'b0;
            fetch_in = 1'b0;
            wb_in    = 1'b0;
            state_in = S_OUT;
            if (cls_ff.is_flush) begin
               sel_in   = '0;
               state_in = S_FL_RD;
            end else if (cls_ff.is_release) begin
               sel_in = m_idx;
               hit_in = m_any;
               wb_in  = m_any && dirty_ff[m_idx];
            end else if (m_any) begin
               sel_in = m_idx;
               hit_in = 1'b1;
            end else if (f_any) begin
               sel_in   = f_idx;
               fetch_in = 1'b1;
            end else begin
               sel_in   = hand_ff;
               fetch_in = 1'b1;
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            if (ref_ff[sel_ff]) begin
               ref_in[sel_ff] = 1'b0;
               sel_in         = sel_next;
            end else begin
               wb_in    = valid_ff[sel_ff] && dirty_ff[sel_ff];
               hand_in  = sel_next;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (can_emit) begin
               rsp_valid_in            = 1'b1;
               rsp_in.slot             = 6'(sel_ff);
               rsp_in.hit              = hit_ff;
               rsp_in.fetch_needed     = fetch_ff;
               rsp_in.writeback_valid  = wb_ff;
               rsp_in.writeback_sector = wb_ff ? mem_ext[31:0] : 32'd0;
               rsp_in.last             = 1'b1;
               if (cls_ff.is_release) begin
                  if (hit_ff) valid_in[sel_ff] = 1'b0;
               end else if (hit_ff) begin
                  ref_in[sel_ff] = 1'b1;
                  if (cls_ff.is_write) dirty_in[sel_ff] = 1'b1;
               end else begin
                  valid_in[sel_ff] = 1'b1;
                  ref_in[sel_ff]   = 1'b1;
                  dirty_in[sel_ff] = cls_ff.is_write;
                  fill_we          = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_FL_RD: state_in = S_FL_OUT;
         S_FL_OUT: begin
            if (can_emit) begin
               rsp_valid_in            = 1'b1;
               rsp_in.slot             = 6'(sel_ff);
               rsp_in.hit              = valid_ff[sel_ff];
               rsp_in.fetch_needed     = 1'b0;
               rsp_in.writeback_valid  = valid_ff[sel_ff] && dirty_ff[sel_ff];
               rsp_in.writeback_sector = (valid_ff[sel_ff] && dirty_ff[sel_ff]) ?
                                         mem_ext[31:0] : 32'd0;
               rsp_in.last             = (sel_ff == LAST_SLOT);
               if (sel_ff == LAST_SLOT) begin
                  state_in = S_IDLE;
               end else begin
                  sel_in   = sel_next;
                  state_in = S_FL_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cls_ff <= q_cls;
         sec_ff <= q_sector;
      end
      match_ff <= match_in;
      mem_q_ff <= mem[sel_in];
      if (fill_we) begin
         mem[sel_ff]    <= sec_ff;
         tag_ff[sel_ff] <= sec_ff;
      end
      sel_ff   <= sel_in;
      hit_ff   <= hit_in;
      fetch_ff <= fetch_in;
      wb_ff    <= wb_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         ref_ff       <= '0;
         dirty_ff     <= '0;
         hand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         ref_ff       <= ref_in;
         dirty_ff     <= dirty_in;
         hand_ff      <= hand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SCTC_ASSERT(a_hand_range, clock, reset, hand_ff <= LAST_SLOT, "clock hand out of range")
   `SCTC_ASSERT(a_sweep_full, clock, reset, (state_ff == S_SWEEP) |-> (&valid_ff), "sweep with free slot")
   `SCTC_ASSERT(a_hand_moves, clock, reset, !$stable(hand_ff) |-> ($past(state_ff) == S_SWEEP), "hand moved outside sweep")
endmodule

@@ rtl/sector_cache_clock_tags_core.sv @@
// Sector cache tag engine top level: request queue feeding the tag and policy back end
// A lookup or release is queued, popped, matched, picked and registered as the result;
// a miss with all slots valid sweeps the clock hand to a slot with reference bit clear.
// One request at a time: the back end pops the next once the result is registered.
// Flush reads, then emits, each slot in turn; the sector memory has a single read port.
// Reset: synchronous; all slots invalid, hand at slot 0, queue empty, no clearing pass.
module sector_cache_clock_tags_core #(
   parameter int CACHE_SLOTS = sctc_pkg::DEF_CACHE_SLOTS,
   parameter int SECTOR_BITS = sctc_pkg::DEF_SECTOR_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sctc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sctc_pkg::rsp_type rsp_payload
);
   logic                   q_valid, q_pop;
   sctc_pkg::cls_type      q_cls;
   logic [SECTOR_BITS-1:0] q_sector;

   sctc_front #(.SECTOR_BITS(SECTOR_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_cls       (q_cls),
      .q_sector    (q_sector),
      .q_pop       (q_pop)
   );

   sctc_back #(.CACHE_SLOTS(CACHE_SLOTS), .SECTOR_BITS(SECTOR_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cls       (q_cls),
      .q_sector    (q_sector),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );
endmodule

@@ verif/sector_cache_clock_tags_checker.sv @@
// Checker for the sector cache tag engine: predicts results and compares transactions
`timescale 1ns / 100ps
module sector_cache_clock_tags_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  sctc_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  sctc_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                pending_count,
   output int                rsp_count
);
   localparam int SLOTS = sctc_pkg::DEF_CACHE_SLOTS;

   logic              tag_valid [SLOTS];
   logic [31:0]       tag_sector [SLOTS];
   logic              tag_ref [SLOTS];
   logic              tag_dirty [SLOTS];
   logic [5:0]        hand;
   sctc_pkg::rsp_type expected_rsps [$];

   function automatic sctc_pkg::rsp_type make_rsp(logic [5:0] s, logic h, logic f, logic w,
                                                  logic [31:0] ws, logic l);
      sctc_pkg::rsp_type r;
      r.slot = s; r.hit = h; r.fetch_needed = f; r.writeback_valid = w;
      r.writeback_sector = w ? ws : 32'd0; r.last = l;
      return r;
   endfunction

   task automatic predict_lookup(sctc_pkg::req_type rq);
      int m;
      int v;
      logic w;
      m = -1;
      v = -1;
      if (rq.op == sctc_pkg::OP_FLUSH) begin
         for (int i = 0; i < SLOTS; i++)
            expected_rsps.push_back(make_rsp(6'(i), tag_valid[i], 1'b0,
               tag_valid[i] && tag_dirty[i], tag_sector[i], i == SLOTS - 1));
         return;
      end
      for (int i = SLOTS - 1; i >= 0; i--)
         if (tag_valid[i] && tag_sector[i] == rq.sector) m = i;
      if (rq.op == sctc_pkg::OP_RELEASE) begin
         if (m < 0) expected_rsps.push_back(make_rsp(6'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1));
         else begin
            tag_valid[m] = 1'b0;
            expected_rsps.push_back(make_rsp(6'(m), 1'b1, 1'b0, tag_dirty[m],
                                             tag_sector[m], 1'b1));
         end
         return;
      end
      if (m >= 0) begin
         tag_ref[m] = 1'b1;
         if (rq.op == sctc_pkg::OP_WRITE) tag_dirty[m] = 1'b1;
         expected_rsps.push_back(make_rsp(6'(m), 1'b1, 1'b0, 1'b0, 32'd0, 1'b1));
         return;
      end
      for (int i = SLOTS - 1; i >= 0; i--)
         if (!tag_valid[i]) v = i;
      if (v < 0) begin
         while (tag_ref[hand]) begin
            tag_ref[hand] = 1'b0;
            hand = hand + 6'd1;
         end
         v = int'(hand);
         hand = hand + 6'd1;
      end
      w = tag_valid[v] && tag_dirty[v];
      expected_rsps.push_back(make_rsp(6'(v), 1'b0, 1'b1, w, tag_sector[v], 1'b1));
      tag_valid[v] = 1'b1;
      tag_ref[v] = 1'b1;
      tag_sector[v] = rq.sector;
      tag_dirty[v] = (rq.op == sctc_pkg::OP_WRITE);
   endtask

   always @(posedge clock) begin
      sctc_pkg::rsp_type exp_rsp;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            tag_valid[i] = 1'b0; tag_sector[i] = 32'd0; tag_ref[i] = 1'b0;
            tag_dirty[i] = 1'b0;
         end
         hand = 6'd0;
         expected_rsps.delete();
         fail_count = 0;
         rsp_count = 0;
      end else begin
         if (req_valid && req_ready) predict_lookup(req_payload);
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               $error("unexpected transaction %p", rsp_payload);
               fail_count++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_payload.slot !== exp_rsp.slot) begin
                  $error("slot: expected %0d actual %0d", exp_rsp.slot, rsp_payload.slot);
                  fail_count++;
               end
               if (rsp_payload.hit !== exp_rsp.hit) begin
                  $error("hit: expected %0b actual %0b", exp_rsp.hit, rsp_payload.hit);
                  fail_count++;
               end
               if (rsp_payload.fetch_needed !== exp_rsp.fetch_needed) begin
                  $error("fetch_needed: expected %0b actual %0b",
                         exp_rsp.fetch_needed, rsp_payload.fetch_needed);
                  fail_count++;
               end
               if (rsp_payload.writeback_valid !== exp_rsp.writeback_valid) begin
                  $error("writeback_valid: expected %0b actual %0b",
                         exp_rsp.writeback_valid, rsp_payload.writeback_valid);
                  fail_count++;
               end
               if (rsp_payload.writeback_sector !== exp_rsp.writeback_sector) begin
                  $error("writeback_sector: expected %h actual %h",
                         exp_rsp.writeback_sector, rsp_payload.writeback_sector);
                  fail_count++;
               end
               if (rsp_payload.last !== exp_rsp.last) begin
                  $error("last: expected %0b actual %0b", exp_rsp.last, rsp_payload.last);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_rsps.size();
   end
endmodule

@@ verif/tb_sector_cache_clock_tags_core.sv @@
// Testbench top for the sector cache tag engine: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_sector_cache_clock_tags_core;
   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   sctc_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   sctc_pkg::rsp_type rsp_payload;
   int                fail_count;
   int                pending_count;
   int                rsp_count;
   int                sent_count;
   bit                quiet_phase;
   bit                hold_rsp;
   logic [31:0]       sector_pool [8];

   sector_cache_clock_tags_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   sector_cache_clock_tags_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .fail_count(fail_count), .pending_count(pending_count), .rsp_count(rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("FAIL");
      $finish;
   end

   task automatic send_transaction(logic [1:0] op, logic [31:0] sector);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{op: op, sector: sector};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_count++;
   endtask

   function automatic logic [31:0] pick_sector();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 79);
         default: return sector_pool[$urandom_range(0, 7)];
      endcase
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      hold_rsp = 1'b0;
      quiet_phase = 1'b0;
      sent_count = 0;
      foreach (sector_pool[i]) sector_pool[i] = $urandom();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_transaction(sctc_pkg::OP_RELEASE, 32'd0);
      send_transaction(sctc_pkg::OP_READ, 32'd0);
      send_transaction(sctc_pkg::OP_WRITE, 32'hFFFF_FFFF);
      send_transaction(sctc_pkg::OP_READ, 32'hFFFF_FFFF);
      send_transaction(sctc_pkg::OP_WRITE, 32'd0);
      send_transaction(sctc_pkg::OP_FLUSH, 32'h5555_AAAA);
      send_transaction(sctc_pkg::OP_RELEASE, 32'hFFFF_FFFF);
      send_transaction(sctc_pkg::OP_RELEASE, 32'h1234_5678);
      send_transaction(sctc_pkg::OP_RELEASE, 32'd0);
      // fill every slot, then force clock sweeps with dirty victims
      for (int i = 0; i < 64; i++) send_transaction(sctc_pkg::OP_WRITE, 32'h100 + i);
      hold_rsp = 1'b1;
      for (int i = 0; i < 6; i++) send_transaction(sctc_pkg::OP_READ, 32'hA000 + i);
      hold_rsp = 1'b0;
      send_transaction(sctc_pkg::OP_READ, 32'h101);
      send_transaction(sctc_pkg::OP_FLUSH, 32'd0);
      for (int i = 0; i < 88; i++) begin
         if (i == 70) quiet_phase = 1'b1;
         case ($urandom_range(0, 19))
            0: send_transaction(sctc_pkg::OP_FLUSH, $urandom());
            1, 2, 3: send_transaction(sctc_pkg::OP_RELEASE, pick_sector());
            4, 5, 6, 7, 8, 9, 10: send_transaction(sctc_pkg::OP_WRITE, pick_sector());
            default: send_transaction(sctc_pkg::OP_READ, pick_sector());
         endcase
      end
      send_transaction(sctc_pkg::OP_FLUSH, 32'd0);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("Covered %0d requests and %0d results: misses, sweeps, writebacks, flushes.",
               sent_count, rsp_count);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      int hold_cycles;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            hold_cycles = 200;
            while (hold_cycles > 0) begin
               @(negedge clock);
               hold_cycles--;
            end
            rsp_ready <= 1'b1;
            while (hold_rsp) @(negedge clock);
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sctc_pkg.sv
rtl/sctc_front.sv
rtl/sctc_back.sv
rtl/sector_cache_clock_tags_core.sv
verif/sector_cache_clock_tags_checker.sv
verif/tb_sector_cache_clock_tags_core.sv
